/* design/fsfl_pkg.sv */
`timescale 1ns / 1ps

package fsfl_pkg;

  // Pool geometry
  localparam int MAX_SLOTS = 1024;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = IDX_W + 1;
  localparam int ADDR_W    = 48;
  localparam int SIZE_W    = 17;
  localparam int LINK_W    = IDX_W + 1;   // {valid, next index}
  localparam int PROD_W    = IDX_W + SIZE_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SLOT   = 2'd1,
    STAT_NONE_USED = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_COUNT   = 2'd0,
    CFG_BASE_ADDRESS = 2'd1,
    CFG_SLOT_SIZE    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [IDX_W-1:0] slot_index;
    logic             no_pointer;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  granted_index;
    logic [ADDR_W-1:0] granted_address;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  used_count;
  } rsp_t;

endpackage

/* design/fsfl_ram.sv */
`timescale 1ns / 1ps

module fsfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/fixed_slot_free_list_allocator.sv */
`timescale 1ns / 1ps
// A command taken while idle gives its result word on rsp, with done high for one
// cycle, after the exec state. No new command is taken while busy, the exec
// state that waits on the registered read of the link memory ahead of the update.
// Results cannot be stalled. Reset (rst, synchronous) leaves an empty, freshly
// initialised pool and restores slot_count 1024, base_address 0, slot_size 8.
module fixed_slot_free_list_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  fsfl_pkg::cmd_t                 cmd,
  output logic                           done,
  output fsfl_pkg::rsp_t                 rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fsfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsfl_pkg::ADDR_W-1:0]    cfg_data
);

  import fsfl_pkg::*;

  state_t            state, state_next;
  cmd_t              cmd_q;
  logic [CNT_W-1:0]  slot_count;
  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] slot_size;
  logic [IDX_W-1:0]  list_head, list_head_next;
  logic              head_valid, head_valid_next;
  logic [CNT_W-1:0]  fill_pointer, fill_pointer_next;
  logic [CNT_W-1:0]  in_use, in_use_next;
  rsp_t              rsp_next;

  logic              accept;
  logic [CNT_W-1:0]  eff_count;
  logic              got;
  logic [IDX_W-1:0]  slot;
  logic [PROD_W-1:0] prod;
  logic              ram_we;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  assign busy      = (state == ST_EXEC);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign eff_count = (slot_count > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count;

  // link memory: {valid, next index} per slot, read at the head on accept
  fsfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cmd_q.slot_index),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (list_head),
    .rd_data (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count   <= CNT_W'(1024);
      base_address <= '0;
      slot_size    <= SIZE_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOT_COUNT:   slot_count   <= cfg_data[CNT_W-1:0];
        CFG_BASE_ADDRESS: base_address <= cfg_data;
        CFG_SLOT_SIZE:    slot_size    <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // state, pool registers and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      list_head    <= '0;
      head_valid   <= 1'b0;
      fill_pointer <= '0;
      in_use       <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      list_head    <= list_head_next;
      head_valid   <= head_valid_next;
      fill_pointer <= fill_pointer_next;
      in_use       <= in_use_next;
      done         <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

  // next state and read-modify-write of the free list
  always_comb begin
    state_next        = state;
    list_head_next    = list_head;
    head_valid_next   = head_valid;
    fill_pointer_next = fill_pointer;
    in_use_next       = in_use;
    ram_we            = 1'b0;
    ram_wdata         = {head_valid, list_head};
    got               = 1'b0;
    slot              = '0;
    rsp_next          = '0;
    rsp_next.status   = STAT_OK;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        unique case (cmd_q.opcode)
          OP_INIT: begin
            list_head_next    = '0;
            head_valid_next   = 1'b0;
            fill_pointer_next = '0;
            in_use_next       = '0;
          end
          OP_ALLOC: begin
            // stacked slots first, then the fill pointer
            if (head_valid) begin
              slot            = list_head;
              head_valid_next = ram_rdata[LINK_W-1];
              list_head_next  = ram_rdata[IDX_W-1:0];
              got             = 1'b1;
            end else if (fill_pointer < eff_count) begin
              slot              = fill_pointer[IDX_W-1:0];
              fill_pointer_next = fill_pointer + CNT_W'(1);
              got               = 1'b1;
            end
            if (got) begin
              in_use_next = in_use + CNT_W'(1);
            end else begin
              rsp_next.status = STAT_NO_SLOT;
            end
          end
          OP_FREE: begin
            if (!cmd_q.no_pointer) begin
              if ({1'b0, cmd_q.slot_index} >= eff_count) begin
                rsp_next.status = STAT_RANGE;
              end else if (in_use == '0) begin
                rsp_next.status = STAT_NONE_USED;
              end else begin
                ram_we          = 1'b1;
                list_head_next  = cmd_q.slot_index;
                head_valid_next = 1'b1;
                in_use_next     = in_use - CNT_W'(1);
              end
            end
          end
          OP_NOP: ;
        endcase
      end
    endcase

    // address of the granted slot
    prod = PROD_W'(slot) * PROD_W'(slot_size);
    if (got) begin
      rsp_next.granted_index   = slot;
      rsp_next.granted_address = base_address + ADDR_W'(prod);
    end
    rsp_next.used_count = in_use_next;
    rsp_next.free_count = (eff_count > in_use_next) ? (eff_count - in_use_next) : '0;
  end

endmodule

/* design/fsfl_checker.sv */
`timescale 1ns / 1ps

module fsfl_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input fsfl_pkg::rsp_t rsp
);

  import fsfl_pkg::*;

  // a taken command makes the block busy, and done follows the busy cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command taken but block not busy");

  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("no result word two cycles after command");

  // at most one result word per command
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // only a granted allocate carries an index or address
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != STAT_OK |-> rsp.granted_index == '0 && rsp.granted_address == '0)
    else $error("failed command reports a granted slot");

  // free plus used never exceeds the pool size
  a_counts: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, rsp.free_count} + {1'b0, rsp.used_count}) <= (CNT_W + 1)'(MAX_SLOTS))
    else $error("free and used counts exceed pool size");

endmodule

bind fixed_slot_free_list_allocator fsfl_checker u_fsfl_checker (.*);
